FILE: src/fud_pkg.sv
// shared constants and types for the file upload deframer
`timescale 1ns / 1ps

package fud_pkg;

  localparam int NameBufferBytes = 64;
  localparam int NameCntW        = $clog2(NameBufferBytes);

  typedef enum logic [3:0] {
    ActSizeByte   = 4'd0,
    ActNameChar   = 4'd1,
    ActNameDone   = 4'd2,
    ActOpen       = 4'd3,
    ActEmptyFile  = 4'd4,
    ActWrite      = 4'd5,
    ActWriteClose = 4'd6,
    ActEmptyName  = 4'd7,
    ActNameLong   = 4'd8
  } action_e;

endpackage

FILE: src/file_upload_deframer.sv
// file upload deframer: splits a byte stream into name, length and data items
// an accepted input item yields its result item on the outputs in the next cycle
// throughput: one item per cycle unless the output stalls; parser state and
//   result register update in the same cycle from one compare and counter step
// reset: asynchronous active low; parser returns to expecting a file name,
//   counters clear and the result register is emptied
`timescale 1ns / 1ps

module file_upload_deframer import fud_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  action_o,
  output logic [7:0]  out_byte_o,
  output logic [5:0]  name_index_o,
  output logic [5:0]  name_length_o,
  output logic [31:0] file_length_o
);

  typedef enum logic [1:0] {
    PhName   = 2'd0,
    PhLength = 2'd1,
    PhData   = 2'd2
  } phase_e;

  phase_e              phase_q, phase_d;
  logic [NameCntW-1:0] name_cnt_q, name_cnt_d;
  logic [1:0]          len_cnt_q, len_cnt_d;
  logic [23:0]         len_part_q, len_part_d;
  logic [31:0]         remaining_q, remaining_d;

  logic                out_valid_q;
  action_e             action_q, action_d;
  logic [7:0]          out_byte_q, out_byte_d;
  logic [5:0]          name_index_q, name_index_d;
  logic [5:0]          name_length_q, name_length_d;
  logic [31:0]         file_length_q, file_length_d;

  logic                in_accept;
  logic [31:0]         len_full;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;
  assign len_full   = {rx_byte_i, len_part_q};

  always_comb begin
    phase_d       = phase_q;
    name_cnt_d    = name_cnt_q;
    len_cnt_d     = len_cnt_q;
    len_part_d    = len_part_q;
    remaining_d   = remaining_q;
    action_d      = ActSizeByte;
    out_byte_d    = 8'd0;
    name_index_d  = 6'd0;
    name_length_d = 6'd0;
    file_length_d = 32'd0;
    case (phase_q)
      PhLength: begin
        if (len_cnt_q != 2'd3) begin
          case (len_cnt_q)
            2'd0:    len_part_d[7:0]   = rx_byte_i;
            2'd1:    len_part_d[15:8]  = rx_byte_i;
            default: len_part_d[23:16] = rx_byte_i;
          endcase
          len_cnt_d = len_cnt_q + 2'd1;
          action_d  = ActSizeByte;
        end else begin
          name_length_d = 6'(name_cnt_q);
          file_length_d = len_full;
          len_cnt_d     = 2'd0;
          len_part_d    = 24'd0;
          if (len_full == 32'd0) begin
            action_d   = ActEmptyFile;
            phase_d    = PhName;
            name_cnt_d = '0;
          end else begin
            action_d    = ActOpen;
            remaining_d = len_full;
            phase_d     = PhData;
          end
        end
      end
      PhData: begin
        out_byte_d = rx_byte_i;
        if (remaining_q == 32'd1) begin
          action_d    = ActWriteClose;
          phase_d     = PhName;
          name_cnt_d  = '0;
          remaining_d = 32'd0;
        end else begin
          action_d    = ActWrite;
          remaining_d = remaining_q - 32'd1;
        end
      end
      default: begin
        phase_d = PhName;
        if (rx_byte_i == 8'd0) begin
          if (name_cnt_q == '0) begin
            action_d = ActEmptyName;
          end else begin
            action_d      = ActNameDone;
            name_length_d = 6'(name_cnt_q);
            phase_d       = PhLength;
            len_cnt_d     = 2'd0;
            len_part_d    = 24'd0;
          end
        end else if (name_cnt_q < NameCntW'(NameBufferBytes - 1)) begin
          action_d     = ActNameChar;
          out_byte_d   = rx_byte_i;
          name_index_d = 6'(name_cnt_q);
          name_cnt_d   = name_cnt_q + NameCntW'(1);
        end else begin
          action_d    = ActNameLong;
          name_cnt_d  = '0;
          len_cnt_d   = 2'd0;
          len_part_d  = 24'd0;
          remaining_d = 32'd0;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhName;
      name_cnt_q    <= '0;
      len_cnt_q     <= 2'd0;
      len_part_q    <= 24'd0;
      remaining_q   <= 32'd0;
      out_valid_q   <= 1'b0;
      action_q      <= ActSizeByte;
      out_byte_q    <= 8'd0;
      name_index_q  <= 6'd0;
      name_length_q <= 6'd0;
      file_length_q <= 32'd0;
    end else begin
      if (in_accept) begin
        phase_q       <= phase_d;
        name_cnt_q    <= name_cnt_d;
        len_cnt_q     <= len_cnt_d;
        len_part_q    <= len_part_d;
        remaining_q   <= remaining_d;
        out_valid_q   <= 1'b1;
        action_q      <= action_d;
        out_byte_q    <= out_byte_d;
        name_index_q  <= name_index_d;
        name_length_q <= name_length_d;
        file_length_q <= file_length_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = action_q;
  assign out_byte_o    = out_byte_q;
  assign name_index_o  = name_index_q;
  assign name_length_o = name_length_q;
  assign file_length_o = file_length_q;

  // state always reflects the item held in the result register
  a_name_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ActNameDone) |-> (phase_q == PhLength) && (len_cnt_q == 2'd0))
    else $error("name done without entering length phase");

  a_open_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ActOpen) |-> (phase_q == PhData) && (remaining_q == file_length_o))
    else $error("open without loading remaining count");

  a_close_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == ActWriteClose || action_o == ActEmptyFile ||
                    action_o == ActEmptyName || action_o == ActNameLong)
    |-> (phase_q == PhName) && (name_cnt_q == '0))
    else $error("parser not cleared after end of frame");

  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while result register empty");

endmodule
